/* src/srx_pkg.sv */
// ----------------------------------------------------------------------------
// srx_pkg
// shared types and codes of the serial frame receiver
// ----------------------------------------------------------------------------
`default_nettype none

package srx_pkg;

	// field widths of the channels
	localparam int OPCODE_W = 2;
	localparam int BYTE_W   = 8;
	localparam int STATUS_W = 2;
	localparam int INDEX_W  = 6;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;
	localparam int TIMEOUT_W  = 16;

	// request opcodes
	localparam logic [OPCODE_W-1:0] OP_BYTE = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_TICK = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_READ = 2'd2;

	// result status codes
	localparam logic [STATUS_W-1:0] STATUS_NONE = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_BAD  = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT      = 1'b1;

	// configuration reset values
	localparam logic [BYTE_W-1:0]    START_MARKER_RST = 8'd170;
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST      = 16'd100;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FETCH,
		ST_LOAD,
		ST_NONE
	} srx_state_t;

	// controller to datapath
	typedef struct packed {
		logic take_byte;
		logic tick;
		logic idx_clr;
		logic idx_inc;
		logic rd_en;
		logic load_frame;
		logic load_none;
		logic frame_done;
	} srx_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic frame_ready;
		logic is_last;
		logic slot_free;
	} srx_sts_t;

endpackage

`default_nettype wire

/* src/srx_req_if.sv */
// ----------------------------------------------------------------------------
// srx_req_if
// request channel: opcode and received byte
// ----------------------------------------------------------------------------
`default_nettype none

interface srx_req_if import srx_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [OPCODE_W-1:0] opcode;
	logic [BYTE_W-1:0]   byte_value;

	modport source (output valid, output opcode, output byte_value, input ready);
	modport sink   (input valid, input opcode, input byte_value, output ready);
endinterface

`default_nettype wire

/* src/srx_rsp_if.sv */
// ----------------------------------------------------------------------------
// srx_rsp_if
// response channel: one stored frame byte with its status
// ----------------------------------------------------------------------------
`default_nettype none

interface srx_rsp_if import srx_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [BYTE_W-1:0]   frame_byte;
	logic [INDEX_W-1:0]  byte_index;
	logic                last;

	modport source (output valid, output status, output frame_byte, output byte_index,
		output last, input ready);
	modport sink   (input valid, input status, input frame_byte, input byte_index,
		input last, output ready);
endinterface

`default_nettype wire

/* src/srx_cfg_if.sv */
// ----------------------------------------------------------------------------
// srx_cfg_if
// configuration write channel: register index and data
// ----------------------------------------------------------------------------
`default_nettype none

interface srx_cfg_if import srx_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* src/srx_ram.sv */
// ----------------------------------------------------------------------------
// srx_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module srx_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* src/srx_ctrl.sv */
// ----------------------------------------------------------------------------
// srx_ctrl
// controller: accepts requests and sequences the frame read walk
// ----------------------------------------------------------------------------
`default_nettype none

module srx_ctrl import srx_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                req_valid,
	input  wire logic [OPCODE_W-1:0] req_opcode,
	output      logic                req_ready,
	input  wire srx_sts_t            sts,
	output      srx_cmd_t            cmd
);

	srx_state_t state_q, state_d;
	logic       req_fire;

	assign req_fire = req_valid && req_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_fire && req_opcode == OP_READ) begin
					state_d = sts.frame_ready ? ST_FETCH : ST_NONE;
				end
			end
			ST_FETCH: begin
				state_d = ST_LOAD;
			end
			ST_LOAD: begin
				if (sts.slot_free) begin
					state_d = sts.is_last ? ST_IDLE : ST_FETCH;
				end
			end
			ST_NONE: begin
				if (sts.slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready     = 1'b1;
				cmd.take_byte = req_fire && req_opcode == OP_BYTE;
				cmd.tick      = req_fire && req_opcode == OP_TICK;
				cmd.idx_clr   = req_fire && req_opcode == OP_READ;
			end
			ST_FETCH: begin
				cmd.rd_en = 1'b1;
			end
			ST_LOAD: begin
				cmd.load_frame = sts.slot_free;
				cmd.idx_inc    = sts.slot_free && !sts.is_last;
				cmd.frame_done = sts.slot_free && sts.is_last;
			end
			ST_NONE: begin
				cmd.load_none = sts.slot_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

/* src/srx_dp.sv */
// ----------------------------------------------------------------------------
// srx_dp
// datapath: frame store, checksum, silence counter, config and output register
// ----------------------------------------------------------------------------
`default_nettype none

module srx_dp import srx_pkg::*; #(
	parameter int PAYLOAD_BYTES = 8
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire srx_cmd_t              cmd,
	output      srx_sts_t              sts,
	input  wire logic [BYTE_W-1:0]     byte_value,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output      logic                  out_valid,
	input  wire logic                  out_ready,
	output      logic [STATUS_W-1:0]   out_status,
	output      logic [BYTE_W-1:0]     out_byte,
	output      logic [INDEX_W-1:0]    out_index,
	output      logic                  out_last
);

	localparam int FRAME_BYTES = PAYLOAD_BYTES + 4;
	// stored bytes: everything but the checksum
	localparam int STORE_DEPTH = FRAME_BYTES - 1;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int FILL_W      = $clog2(FRAME_BYTES);

	logic [BYTE_W-1:0]    start_marker_q;
	logic [TIMEOUT_W-1:0] timeout_q;
	logic [TIMEOUT_W-1:0] silence_q;
	logic [FILL_W-1:0]    fill_q;
	logic [BYTE_W-1:0]    sum_q;
	logic                 in_frame_q;
	logic                 frame_ready_q;
	logic                 match_q;
	logic [ADDR_W-1:0]    rd_idx_q;
	logic                 out_valid_q;
	logic [STATUS_W-1:0]  out_status_q;
	logic [BYTE_W-1:0]    out_byte_q;
	logic [INDEX_W-1:0]   out_index_q;
	logic                 out_last_q;

	logic                 byte_live;
	logic                 byte_is_sum;
	logic                 byte_opens;
	logic                 store_we;
	logic [BYTE_W-1:0]    rd_data;

	assign byte_live   = cmd.take_byte && !frame_ready_q;
	assign byte_is_sum = in_frame_q && fill_q == FILL_W'(STORE_DEPTH);
	assign byte_opens  = !in_frame_q && byte_value == start_marker_q;
	assign store_we    = byte_live && ((in_frame_q && !byte_is_sum) || byte_opens);

	// fill count is zero outside a frame, so it also addresses the start byte
	srx_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (store_we),
		.waddr (fill_q[ADDR_W-1:0]),
		.wdata (byte_value),
		.re    (cmd.rd_en),
		.raddr (rd_idx_q),
		.rdata (rd_data)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_marker_q <= START_MARKER_RST;
			timeout_q      <= TIMEOUT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_START_MARKER: start_marker_q <= cfg_data[BYTE_W-1:0];
				CFG_TIMEOUT:      timeout_q      <= cfg_data[TIMEOUT_W-1:0];
				default:          start_marker_q <= start_marker_q;
			endcase
		end
	end

	// frame gathering and silence timeout
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			silence_q     <= '0;
			fill_q        <= '0;
			sum_q         <= '0;
			in_frame_q    <= 1'b0;
			frame_ready_q <= 1'b0;
			match_q       <= 1'b0;
		end else begin
			if (cmd.take_byte) begin
				silence_q <= timeout_q;
			end
			if (byte_live) begin
				if (byte_is_sum) begin
					match_q       <= sum_q == byte_value;
					frame_ready_q <= 1'b1;
					in_frame_q    <= 1'b0;
					fill_q        <= '0;
				end else if (in_frame_q) begin
					sum_q  <= sum_q + byte_value;
					fill_q <= fill_q + 1'b1;
				end else if (byte_opens) begin
					sum_q      <= byte_value;
					fill_q     <= FILL_W'(1);
					in_frame_q <= 1'b1;
				end
			end
			if (cmd.tick) begin
				if (silence_q != '0) begin
					silence_q <= silence_q - 1'b1;
				end
				// counter at zero after this tick drops a partial frame
				if (silence_q <= TIMEOUT_W'(1) && in_frame_q) begin
					in_frame_q <= 1'b0;
					fill_q     <= '0;
					sum_q      <= '0;
				end
			end
			if (cmd.frame_done) begin
				frame_ready_q <= 1'b0;
				sum_q         <= '0;
			end
		end
	end

	// read walk index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q <= '0;
		end else if (cmd.idx_clr) begin
			rd_idx_q <= '0;
		end else if (cmd.idx_inc) begin
			rd_idx_q <= rd_idx_q + 1'b1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_frame || cmd.load_none) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_frame) begin
			out_status_q <= match_q ? STATUS_OK : STATUS_BAD;
			out_byte_q   <= rd_data;
			out_index_q  <= INDEX_W'(rd_idx_q);
			out_last_q   <= sts.is_last;
		end else if (cmd.load_none) begin
			out_status_q <= STATUS_NONE;
			out_byte_q   <= '0;
			out_index_q  <= '0;
			out_last_q   <= 1'b1;
		end
	end

	assign sts.frame_ready = frame_ready_q;
	assign sts.is_last     = rd_idx_q == ADDR_W'(STORE_DEPTH - 1);
	assign sts.slot_free   = !out_valid_q || out_ready;

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_byte   = out_byte_q;
	assign out_index  = out_index_q;
	assign out_last   = out_last_q;

endmodule

`default_nettype wire

/* src/serial_frame_receiver.sv */
// ----------------------------------------------------------------------------
// serial_frame_receiver
// gathers serial bytes into a fixed-length frame with additive checksum and
// plays the stored frame back on request
// ----------------------------------------------------------------------------
//
//  channel  dir  transaction carries
//  -------  ---  ------------------------------------------------------
//  req      in   opcode (byte, tick, read), byte_value
//  rsp      out  status, frame_byte, byte_index, last
//  cfg      in   index (0 start_marker, 1 timeout_reload), data
//
//  byte and tick requests leave the controller idle, so req stays ready
//  a read walks PAYLOAD_BYTES+3 results, each a store read (fetch) then an
//  output load; the registered store read, fetched and loaded one result at
//  a time, sets the pace of the walk
//  a read with no frame ready gives one result, status none, once rsp is free
//  rsp stalls hold the walk in place; the last result sits in the output
//  register while req already takes new transactions
//  arst_n clears control state and config to defaults; no clearing pass
//
`default_nettype none

module serial_frame_receiver import srx_pkg::*; #(
	parameter int PAYLOAD_BYTES = 8
) (
	input wire logic clk,
	input wire logic arst_n,
	srx_req_if.sink   req,
	srx_rsp_if.source rsp,
	srx_cfg_if.sink   cfg
);

	srx_cmd_t cmd;
	srx_sts_t sts;

	// config writes are always taken
	assign cfg.ready = 1'b1;

	// controller: request decode and read walk sequencing
	srx_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req.valid),
		.req_opcode (req.opcode),
		.req_ready  (req.ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	// datapath: store, checksum, silence counter and output register
	srx_dp #(
		.PAYLOAD_BYTES (PAYLOAD_BYTES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.byte_value (req.byte_value),
		.cfg_we     (cfg.valid && cfg.ready),
		.cfg_index  (cfg.index),
		.cfg_data   (cfg.data),
		.out_valid  (rsp.valid),
		.out_ready  (rsp.ready),
		.out_status (rsp.status),
		.out_byte   (rsp.frame_byte),
		.out_index  (rsp.byte_index),
		.out_last   (rsp.last)
	);

	// the output register is never overwritten while its result still waits
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.ready) |-> !(cmd.load_frame || cmd.load_none))
		else $error("output register loaded while a result is stalled");

	// no request is taken while the store is being walked
	a_no_req_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.rd_en || cmd.load_frame) |-> !req.ready)
		else $error("request accepted during frame read");

	// loading the final frame byte shows last on the next cycle
	a_last_marked: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load_frame && sts.is_last) |=> (rsp.valid && rsp.last))
		else $error("final frame result not marked last");

	// finishing a read releases the held frame
	a_frame_released: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.frame_done |=> !sts.frame_ready)
		else $error("frame still held after read");

endmodule

`default_nettype wire

/* dv/serial_frame_receiver_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// serial_frame_receiver_tb
// checks the frame receiver against a cycle-free predictor of its byte, tick
// and read handling; frames, noise, timeouts and reads are sent under random
// sender gaps and receiver stalls, over several marker and timeout settings
// ----------------------------------------------------------------------------
`default_nettype none

module serial_frame_receiver_tb import srx_pkg::*; ();

	localparam int PAYLOAD_BYTES = 8;
	// start, length, command, payload, checksum
	localparam int FRAME_BYTES   = PAYLOAD_BYTES + 4;
	// opcode that the block must ignore
	localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
	// a read walks the store with a fetch and a load per beat; allow some slack on top
	localparam int DRAIN_CYCLES  = 2 * (PAYLOAD_BYTES + 3) + 10;
	localparam int PHASE_ITEMS   = 26;
	localparam int HOLD_CYCLES   = 300;
	localparam int MAX_REPORTS   = 100;
	localparam longint RUN_LIMIT_NS = 2_000_000;

	// one beat of a frame readout
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [BYTE_W-1:0]   frame_byte;
		logic [INDEX_W-1:0]  byte_index;
		logic                last;
	} frame_beat_t;

	// ------------------------------------------------------------------------
	// scoreboard: tracks the receiver state per accepted request and holds the
	// readout beats that are still owed
	// ------------------------------------------------------------------------
	class frame_scoreboard;
		logic [BYTE_W-1:0]    marker;
		logic [TIMEOUT_W-1:0] reload;
		logic [BYTE_W-1:0]    store [FRAME_BYTES];
		int unsigned          fill;
		bit                   gathering;
		bit                   held;
		logic [TIMEOUT_W-1:0] silence;
		logic [BYTE_W-1:0]    sum;
		frame_beat_t          owed_beats [$];
		int                   failures;

		function new();
			marker    = START_MARKER_RST;
			reload    = TIMEOUT_RST;
			foreach (store[i])
				store[i] = '0;
			fill      = 0;
			gathering = 0;
			held      = 0;
			silence   = '0;
			sum       = '0;
			failures  = 0;
		endfunction

		function int pending();
			return owed_beats.size();
		endfunction

		function void flag(string what, int want, int got);
			failures++;
			if (failures <= MAX_REPORTS)
				$error("%s mismatch: expected %0d, actual %0d", what, want, got);
		endfunction

		function void write_register(logic [CFG_IDX_W-1:0] idx,
				logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_START_MARKER: marker = data[BYTE_W-1:0];
				CFG_TIMEOUT:      reload = data[TIMEOUT_W-1:0];
				default: ;
			endcase
		endfunction

		function void note_request(logic [OPCODE_W-1:0] op, logic [BYTE_W-1:0] b);
			logic [STATUS_W-1:0] st;
			frame_beat_t         beat;
			case (op)
				OP_BYTE: begin
					if (!held) begin
						if (gathering) begin
							// everything but the checksum goes into the sum
							if (fill < FRAME_BYTES - 1)
								sum = sum + b;
							store[fill] = b;
							fill++;
							if (fill >= FRAME_BYTES) begin
								held      = 1;
								gathering = 0;
								fill      = 0;
							end
						end else if (b == marker) begin
							store[0]  = b;
							fill      = 1;
							sum       = b;
							gathering = 1;
						end
					end
					silence = reload;
				end
				OP_TICK: begin
					if (silence != 0)
						silence = silence - 1'b1;
					// a held frame is never dropped, only a partial one
					if (silence == 0 && gathering) begin
						gathering = 0;
						fill      = 0;
						sum       = '0;
					end
				end
				OP_READ: begin
					if (!held) begin
						beat = '{status: STATUS_NONE, frame_byte: '0, byte_index: '0,
							last: 1'b1};
						owed_beats.push_back(beat);
					end else begin
						st = (sum == store[FRAME_BYTES-1]) ? STATUS_OK : STATUS_BAD;
						for (int k = 0; k < FRAME_BYTES - 1; k++) begin
							beat.status     = st;
							beat.frame_byte = store[k];
							beat.byte_index = k[INDEX_W-1:0];
							beat.last       = (k == FRAME_BYTES - 2);
							owed_beats.push_back(beat);
						end
						held      = 0;
						gathering = 0;
						fill      = 0;
						sum       = '0;
					end
				end
				default: ;
			endcase
		endfunction

		function void check_beat(frame_beat_t got);
			frame_beat_t want;
			if (owed_beats.size() == 0) begin
				failures++;
				if (failures <= MAX_REPORTS)
					$error("unexpected readout beat: status %0d byte %0d index %0d last %0d",
						got.status, got.frame_byte, got.byte_index, got.last);
				return;
			end
			want = owed_beats.pop_front();
			if (got.status !== want.status)
				flag("status", want.status, got.status);
			if (got.frame_byte !== want.frame_byte)
				flag("frame_byte", want.frame_byte, got.frame_byte);
			if (got.byte_index !== want.byte_index)
				flag("byte_index", want.byte_index, got.byte_index);
			if (got.last !== want.last)
				flag("last", want.last, got.last);
		endfunction

		function void report_leftovers();
			if (owed_beats.size() != 0) begin
				failures++;
				$error("%0d readout beats never arrived", owed_beats.size());
			end
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// clock, reset, channels and the block
	// ------------------------------------------------------------------------
	logic clk = 1'b0;
	logic arst_n = 1'b0;

	srx_req_if req_bus ();
	srx_rsp_if rsp_bus ();
	srx_cfg_if cfg_bus ();

	serial_frame_receiver #(
		.PAYLOAD_BYTES(PAYLOAD_BYTES)
	) uut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_bus),
		.rsp   (rsp_bus),
		.cfg   (cfg_bus)
	);

	frame_scoreboard sb = new();

	// settings the stimulus currently runs under
	logic [BYTE_W-1:0]    cur_marker = START_MARKER_RST;
	logic [TIMEOUT_W-1:0] cur_reload = TIMEOUT_RST;
	// requests sent so far, ignored opcodes not counted
	int unsigned sent_items = 0;
	// transactions left in the current sender burst
	int unsigned burst_left = 0;
	// asks the receiver for one long hold-off
	bit hold_request = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#(RUN_LIMIT_NS);
		$display("serial_frame_receiver_tb: FAIL");
		$finish;
	end

	// ------------------------------------------------------------------------
	// receiver side: ready follows an 8-bit pattern that is re-picked periodically,
	// plus one long hold-off when asked so the block backs up
	// ------------------------------------------------------------------------
	initial begin
		logic [7:0]  pattern;
		int unsigned cyc;
		int unsigned hold_left;
		bit          hold_taken;
		pattern    = 8'hFF;
		cyc        = 0;
		hold_left  = 0;
		hold_taken = 0;
		rsp_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request && !hold_taken) begin
				hold_taken = 1;
				hold_left  = HOLD_CYCLES;
			end
			if (cyc % 32 == 0) begin
				case ($urandom_range(0, 3))
					0: pattern = 8'hFF;                 // no stalls at all
					1: pattern = 8'h01;                 // ready only on bit 0 of the pattern
					default: pattern = 8'($urandom) | (8'h01 << $urandom_range(0, 7));
				endcase
			end
			if (hold_left > 0) begin
				rsp_bus.ready <= 1'b0;
				hold_left--;
			end else begin
				rsp_bus.ready <= pattern[cyc % 8];
			end
			cyc++;
		end
	end

	// readout monitor: every accepted beat goes to the scoreboard
	always @(posedge clk) begin
		if (arst_n && rsp_bus.valid && rsp_bus.ready)
			sb.check_beat('{status: rsp_bus.status, frame_byte: rsp_bus.frame_byte,
				byte_index: rsp_bus.byte_index, last: rsp_bus.last});
	end

	// ------------------------------------------------------------------------
	// sender tasks; each starts and ends just after a falling edge
	// ------------------------------------------------------------------------

	// one request transaction, with a random gap at each burst boundary
	task automatic send_req(logic [OPCODE_W-1:0] op, logic [BYTE_W-1:0] b);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				req_bus.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		req_bus.valid      <= 1'b1;
		req_bus.opcode     <= op;
		req_bus.byte_value <= b;
		do @(posedge clk); while (!req_bus.ready);
		sb.note_request(op, b);
		if (op != OP_UNUSED)
			sent_items++;
		burst_left--;
		@(negedge clk);
	endtask

	task automatic send_byte(logic [BYTE_W-1:0] b);
		send_req(OP_BYTE, b);
	endtask

	task automatic send_tick();
		send_req(OP_TICK, BYTE_W'($urandom_range(0, 255)));
	endtask

	task automatic send_read();
		send_req(OP_READ, BYTE_W'($urandom_range(0, 255)));
	endtask

	// stop offering, let every owed beat come out, then give trailing byte and
	// tick transactions time to finish inside the block
	task automatic settle();
		req_bus.valid <= 1'b0;
		burst_left = 0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// both registers back to back on the config channel
	task automatic apply_settings(logic [BYTE_W-1:0] m, logic [TIMEOUT_W-1:0] r);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= CFG_START_MARKER;
		cfg_bus.data  <= {{(CFG_DATA_W-BYTE_W){1'b0}}, m};
		do @(posedge clk); while (!cfg_bus.ready);
		sb.write_register(CFG_START_MARKER, {{(CFG_DATA_W-BYTE_W){1'b0}}, m});
		@(negedge clk);
		cfg_bus.index <= CFG_TIMEOUT;
		cfg_bus.data  <= r;
		do @(posedge clk); while (!cfg_bus.ready);
		sb.write_register(CFG_TIMEOUT, r);
		@(negedge clk);
		cfg_bus.valid <= 1'b0;
		cur_marker = m;
		cur_reload = r;
	endtask

	// full frame with random content; ticks between bytes stay short of the
	// timeout so the frame survives them
	task automatic send_frame(bit good);
		logic [BYTE_W-1:0] fb [FRAME_BYTES];
		logic [BYTE_W-1:0] acc;
		int unsigned       max_ticks;
		acc = '0;
		fb[0] = cur_marker;
		fb[1] = ($urandom_range(0, 3) == 0) ? BYTE_W'($urandom_range(0, 255)) :
			BYTE_W'(PAYLOAD_BYTES);
		for (int i = 2; i < FRAME_BYTES - 1; i++)
			fb[i] = ($urandom_range(0, 7) == 0) ? cur_marker :
				BYTE_W'($urandom_range(0, 255));
		for (int i = 0; i < FRAME_BYTES - 1; i++)
			acc = acc + fb[i];
		fb[FRAME_BYTES-1] = good ? acc : acc ^ BYTE_W'($urandom_range(1, 255));
		max_ticks = (cur_reload >= 2) ? ((cur_reload - 1 > 3) ? 3 : cur_reload - 1) : 0;
		for (int i = 0; i < FRAME_BYTES; i++) begin
			send_byte(fb[i]);
			if (max_ticks > 0 && i < FRAME_BYTES - 1 && $urandom_range(0, 5) == 0)
				repeat ($urandom_range(1, max_ticks)) send_tick();
		end
	endtask

	// mostly well-formed frames and reads, the rest noise and cut-off frames
	task automatic random_items(int unsigned n);
		int unsigned first;
		int unsigned cut;
		first = sent_items;
		while (sent_items - first < n) begin
			case ($urandom_range(0, 15))
				0, 1, 2, 3, 4, 5, 6, 7, 8: begin
					send_frame($urandom_range(0, 3) != 0);
					// sometimes leave the frame held so later bytes hit it
					if ($urandom_range(0, 7) != 0)
						send_read();
				end
				9, 10: send_byte(BYTE_W'($urandom_range(0, 255)));
				11: repeat ($urandom_range(1, 4)) send_tick();
				12: send_read();
				13: send_req(OP_UNUSED, BYTE_W'($urandom_range(0, 255)));
				default: begin
					// frame cut short: time it out where the timeout is short,
					// else read while it is still open
					cut = $urandom_range(0, FRAME_BYTES - 3);
					send_byte(cur_marker);
					repeat (cut) send_byte(BYTE_W'($urandom_range(0, 255)));
					if (cur_reload <= 6)
						repeat ((cur_reload == 0) ? 1 : cur_reload) send_tick();
					else
						send_read();
				end
			endcase
		end
	endtask

	task automatic run_phase(logic [BYTE_W-1:0] m, logic [TIMEOUT_W-1:0] r, bit squeeze);
		settle();
		apply_settings(m, r);
		if (squeeze)
			hold_request = 1;
		random_items(PHASE_ITEMS);
	endtask

	// ------------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------------
	initial begin
		logic [BYTE_W-1:0] body [FRAME_BYTES];
		logic [BYTE_W-1:0] acc;
		req_bus.valid      = 1'b0;
		req_bus.opcode     = OP_BYTE;
		req_bus.byte_value = '0;
		cfg_bus.valid      = 1'b0;
		cfg_bus.index      = CFG_START_MARKER;
		cfg_bus.data       = '0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: read with nothing stored, ignored opcode, tick while idle
		send_read();
		send_req(OP_UNUSED, 8'hFF);
		send_tick();

		// frame with extreme bytes and the marker inside its payload, a read
		// in the middle that must leave the partial frame alone, and a bad
		// checksum
		body = '{START_MARKER_RST, 8'hFF, 8'h00, 8'hAA, 8'h00, 8'hFF, 8'h01,
			8'h80, 8'h7F, 8'h55, 8'hAA, 8'h00};
		acc = '0;
		for (int i = 0; i < FRAME_BYTES - 1; i++)
			acc = acc + body[i];
		body[FRAME_BYTES-1] = acc ^ 8'h01;
		for (int i = 0; i < FRAME_BYTES; i++) begin
			send_byte(body[i]);
			if (i == 2)
				send_read();
		end
		// byte while a frame is held is dropped
		send_byte(START_MARKER_RST);
		send_read();

		// random phases: reset settings first, then extremes and a few others
		random_items(PHASE_ITEMS);
		run_phase(8'h00, 16'd1, 1'b0);
		run_phase(8'hFF, 16'hFFFF, 1'b1);
		run_phase(8'h5A, 16'd0, 1'b0);
		run_phase(BYTE_W'($urandom_range(0, 255)), TIMEOUT_W'($urandom_range(2, 6)), 1'b0);
		run_phase(8'hAA, 16'd3, 1'b0);

		settle();
		sb.report_leftovers();
		if (sb.failures == 0)
			$display("serial_frame_receiver_tb: PASS");
		else
			$display("serial_frame_receiver_tb: FAIL");
		$finish;
	end

endmodule

`default_nettype wire

/* serial_frame_receiver.f */
src/srx_pkg.sv
src/srx_req_if.sv
src/srx_rsp_if.sv
src/srx_cfg_if.sv
src/srx_ram.sv
src/srx_ctrl.sv
src/srx_dp.sv
src/serial_frame_receiver.sv
dv/serial_frame_receiver_tb.sv
